/* rtl/core/priority_ready_queue_scheduler_defines.svh */
// Assertion macros for the scheduler RTL.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF

// Checks that the consequent holds in the same cycle as the antecedent.
`define PRQS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`else

`define PRQS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/prqs_pkg.sv */
// Types, constants and helper functions of the priority ready-queue scheduler.
`default_nettype none

package prqs_pkg;

    localparam int NUM_THREADS = 32;
    localparam int NUM_LEVELS  = 32;
    localparam int THR_W       = $clog2(NUM_THREADS);
    localparam int LVL_W       = $clog2(NUM_LEVELS);

    localparam logic [4:0] Q_BASE   = 5'd6;
    localparam logic [4:0] Q_MIN    = 5'd2;
    localparam logic [4:0] RT_LEVEL = 5'd16;
    localparam logic [3:0] QMAX_RESET = 4'd12;

    // Configuration register indexes.
    localparam logic CFG_IDLE_THREAD = 1'b0;
    localparam logic CFG_QUANTUM_MAX = 1'b1;

    typedef enum logic [1:0] {
        CMD_INS_TAIL = 2'd0,
        CMD_INS_HEAD = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_SELECT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_QUEUED   = 2'd1,
        ST_UNQUEUED = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_THR,
        S_SEL_LVL,
        S_SEL_THR,
        S_RM_LVL,
        S_RM_FIX,
        S_INS_LVL,
        S_INS_FIX
    } t_state;

    typedef struct packed {
        t_cmd       command;
        logic [4:0] thread_id;
        logic [4:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic [4:0] out_thread;
        logic [4:0] out_level;
        logic [3:0] quantum;
        logic       went_idle;
        logic       preempt;
        t_status    status;
    } t_out_item;

    typedef struct packed {
        logic [4:0] idle_thread;
        logic [3:0] quantum_max;
    } t_cfg;

    // One entry of the level table.
    typedef struct packed {
        logic [THR_W-1:0] head;
        logic [THR_W-1:0] tail;
    } t_lvl_ent;

    // One entry of the thread table.
    typedef struct packed {
        logic [THR_W-1:0] next;
        logic [THR_W-1:0] prev;
        logic [LVL_W-1:0] lvl;
    } t_thr_ent;

    localparam t_lvl_ent LVL_M_HEAD = '{head: '1, tail: '0};
    localparam t_lvl_ent LVL_M_TAIL = '{head: '0, tail: '1};
    localparam t_lvl_ent LVL_M_ALL  = '{head: '1, tail: '1};
    localparam t_thr_ent THR_M_NEXT = '{next: '1, prev: '0, lvl: '0};
    localparam t_thr_ent THR_M_PREV = '{next: '0, prev: '1, lvl: '0};
    localparam t_thr_ent THR_M_LVL  = '{next: '0, prev: '0, lvl: '1};

    typedef struct packed {
        logic             rd_en;
        logic [LVL_W-1:0] rd_addr;
        logic             wr_en;
        logic [LVL_W-1:0] wr_addr;
        t_lvl_ent         wr_data;
        t_lvl_ent         wr_mask;
    } t_lvl_req;

    typedef struct packed {
        logic             rd_en;
        logic [THR_W-1:0] rd_addr;
        logic             wr_en;
        logic [THR_W-1:0] wr_addr;
        t_thr_ent         wr_data;
        t_thr_ent         wr_mask;
    } t_thr_req;

    function automatic logic [3:0] calc_quantum(input logic [4:0] level,
                                                input logic [3:0] qmax);
        logic [4:0] q;
        logic [4:0] dec;
        dec = '0;
        if (level >= RT_LEVEL) begin
            q = Q_BASE + ((level - RT_LEVEL) >> 1);
        end else begin
            dec = (RT_LEVEL - level) >> 2;
            q = (dec >= Q_BASE) ? 5'd0 : Q_BASE - dec;
        end
        // The lower bound is tested first, so a tiny quantum_max still wins above it.
        if (q < Q_MIN) begin
            q = Q_MIN;
        end else if (q > {1'b0, qmax}) begin
            q = {1'b0, qmax};
        end
        return q[3:0];
    endfunction

    function automatic logic [LVL_W-1:0] sat_level(input logic [4:0] p);
        if (32'(p) >= NUM_LEVELS) begin
            return LVL_W'(NUM_LEVELS - 1);
        end
        return LVL_W'(p);
    endfunction

    function automatic logic thread_ok(input logic [4:0] t);
        return 32'(t) < NUM_THREADS;
    endfunction

    // Index of the highest set bit; zero for an empty map.
    function automatic logic [LVL_W-1:0] top_level(input logic [NUM_LEVELS-1:0] bm);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (bm[i]) begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/priority_ready_queue_scheduler.sv */
// Priority ready-queue scheduler: a sequencer over a level table and a thread table, with
// the result held in an output register and two configuration registers.
// Each beat on the input channel is one command (insert at tail, insert at head, remove,
// select next) and yields exactly one result beat. Items are handled one at a time: a
// command holds the input closed from its acceptance until its chain of dependent reads
// and writes on the level and thread tables is done, shortest for select with every level
// empty and longest for insert into a non-empty level or removal from the middle of a list;
// each table is a RAM with one write and one registered read port.
// A result waiting in the output register delays only the next command's first step.
// Ready levels and queued threads are tracked in flip-flops, so there is no clearing pass
// after reset. Configuration may be written whenever no command is in flight.
`default_nettype none

`include "priority_ready_queue_scheduler_defines.svh"

module priority_ready_queue_scheduler
    import prqs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_index,
    input  wire logic [4:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_out_valid;
    t_out_item  r_out_data;

    logic       w_out_free;
    logic       w_res_load;
    t_out_item  w_res;
    t_lvl_req   w_lvl_req;
    t_lvl_ent   w_lvl_rd;
    t_thr_req   w_thr_req;
    t_thr_ent   w_thr_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_thread <= '0;
            r_cfg.quantum_max <= QMAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDLE_THREAD: r_cfg.idle_thread <= i_cfg_data;
                CFG_QUANTUM_MAX: r_cfg.quantum_max <= i_cfg_data[3:0];
            endcase
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    prqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_out_free (w_out_free),
        .o_res_load (w_res_load),
        .o_res      (w_res),
        .o_lvl_req  (w_lvl_req),
        .i_lvl_rd   (w_lvl_rd),
        .o_thr_req  (w_thr_req),
        .i_thr_rd   (w_thr_rd)
    );

    prqs_ram #(
        .WIDTH ($bits(t_lvl_ent)),
        .DEPTH (NUM_LEVELS)
    ) u_lvl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_lvl_req.wr_en),
        .i_wr_addr (w_lvl_req.wr_addr),
        .i_wr_data (w_lvl_req.wr_data),
        .i_wr_mask (w_lvl_req.wr_mask),
        .i_rd_en   (w_lvl_req.rd_en),
        .i_rd_addr (w_lvl_req.rd_addr),
        .o_rd_data (w_lvl_rd)
    );

    prqs_ram #(
        .WIDTH ($bits(t_thr_ent)),
        .DEPTH (NUM_THREADS)
    ) u_thr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_thr_req.wr_en),
        .i_wr_addr (w_thr_req.wr_addr),
        .i_wr_data (w_thr_req.wr_data),
        .i_wr_mask (w_thr_req.wr_mask),
        .i_rd_en   (w_thr_req.rd_en),
        .i_rd_addr (w_thr_req.rd_addr),
        .o_rd_data (w_thr_rd)
    );

    // A result must never land on one that has not been taken yet.
    `PRQS_ASSERT_SAME(a_load_free, i_clk, i_rst_n, w_res_load, !r_out_valid || !i_out_stall)
    // Only one command is in flight: an accepted beat closes the input at once.
    `PRQS_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // No result appears while the sequencer is waiting for a command.
    `PRQS_ASSERT_SAME(a_no_stray_res, i_clk, i_rst_n, !o_in_stall, !w_res_load)

endmodule

`default_nettype wire

/* rtl/core/prqs_ram.sv */
// Generic single-clock RAM with a bit-masked write port and a registered read port.
`default_nettype none

module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [WIDTH-1:0]         i_wr_mask,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= (r_mem[i_wr_addr] & ~i_wr_mask) | (i_wr_data & i_wr_mask);
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/core/prqs_ctrl.sv */
// Command sequencer: ready bitmap, queued flags and the linked-list updates.
`default_nettype none

module prqs_ctrl
    import prqs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_out_free,
    output logic           o_res_load,
    output t_out_item      o_res,
    output t_lvl_req       o_lvl_req,
    input  wire t_lvl_ent  i_lvl_rd,
    output t_thr_req       o_thr_req,
    input  wire t_thr_ent  i_thr_rd
);

    t_state                r_state, n_state;
    logic [NUM_LEVELS-1:0] r_bitmap, n_bitmap;
    logic [NUM_THREADS-1:0] r_queued, n_queued;
    logic [LVL_W-1:0]      r_run_level, n_run_level;
    logic                  r_run_valid, n_run_valid;

    t_in_item              r_item;
    logic [LVL_W-1:0]      r_lv, n_lv;
    logic [THR_W-1:0]      r_t, n_t;
    logic [THR_W-1:0]      r_nx, n_nx;
    logic [THR_W-1:0]      r_pv, n_pv;
    logic [THR_W-1:0]      r_other, n_other;
    t_lvl_ent              r_lvl_ent, n_lvl_ent;

    t_cmd                  w_cmd;
    logic [THR_W-1:0]      w_tid;
    logic [LVL_W-1:0]      w_prio;
    logic                  w_tid_ok;
    logic                  w_bm_empty;
    logic                  w_queued;
    logic                  w_bit_set;
    logic                  w_is_head;
    logic                  w_is_tail;
    logic                  w_preempt;

    assign w_cmd      = r_item.command;
    assign w_tid      = THR_W'(r_item.thread_id);
    assign w_prio     = sat_level(r_item.priority_req);
    assign w_tid_ok   = thread_ok(r_item.thread_id);
    assign w_bm_empty = (r_bitmap == '0);
    assign w_queued   = r_queued[w_tid];
    assign w_bit_set  = r_bitmap[w_prio];
    assign w_is_head  = (i_lvl_rd.head == r_t);
    assign w_is_tail  = (i_lvl_rd.tail == r_t);
    assign w_preempt  = r_run_valid && (w_prio > r_run_level);

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                // Wait for a free output register so that the result never overwrites one.
                if (i_out_free) begin
                    priority if (w_cmd == CMD_SELECT) begin
                        n_state = w_bm_empty ? S_IDLE : S_SEL_LVL;
                    end else if (!w_tid_ok) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_THR;
                    end
                end
            end
            S_SEL_LVL: n_state = S_SEL_THR;
            S_SEL_THR: n_state = S_IDLE;
            S_THR: begin
                if (w_cmd == CMD_REMOVE) begin
                    n_state = w_queued ? S_RM_LVL : S_IDLE;
                end else begin
                    n_state = (w_queued || !w_bit_set) ? S_IDLE : S_INS_LVL;
                end
            end
            S_RM_LVL:  n_state = (!w_is_head && !w_is_tail) ? S_RM_FIX : S_IDLE;
            S_RM_FIX:  n_state = S_IDLE;
            S_INS_LVL: n_state = S_INS_FIX;
            S_INS_FIX: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_lvl_req   = '0;
        o_thr_req   = '0;
        o_res_load  = 1'b0;
        o_res       = '0;
        n_bitmap    = r_bitmap;
        n_queued    = r_queued;
        n_run_level = r_run_level;
        n_run_valid = r_run_valid;
        n_lv        = r_lv;
        n_t         = r_t;
        n_nx        = r_nx;
        n_pv        = r_pv;
        n_other     = r_other;
        n_lvl_ent   = r_lvl_ent;

        unique case (r_state)
            S_START: begin
                if (i_out_free) begin
                    priority if (w_cmd == CMD_SELECT) begin
                        if (w_bm_empty) begin
                            o_res_load        = 1'b1;
                            o_res.out_thread  = i_cfg.idle_thread;
                            o_res.quantum     = calc_quantum(5'd0, i_cfg.quantum_max);
                            o_res.went_idle   = 1'b1;
                            n_run_level       = '0;
                            n_run_valid       = 1'b1;
                        end else begin
                            n_lv              = top_level(r_bitmap);
                            o_lvl_req.rd_en   = 1'b1;
                            o_lvl_req.rd_addr = top_level(r_bitmap);
                        end
                    end else if (!w_tid_ok) begin
                        o_res_load       = 1'b1;
                        o_res.out_thread = r_item.thread_id;
                        o_res.status     = ST_UNQUEUED;
                    end else begin
                        o_thr_req.rd_en   = 1'b1;
                        o_thr_req.rd_addr = w_tid;
                    end
                end
            end
            S_SEL_LVL: begin
                n_t               = i_lvl_rd.head;
                n_lvl_ent         = i_lvl_rd;
                o_thr_req.rd_en   = 1'b1;
                o_thr_req.rd_addr = i_lvl_rd.head;
            end
            S_SEL_THR: begin
                // The selected thread is the head, so only the level entry can change.
                if (r_lvl_ent.tail == r_t) begin
                    n_bitmap[r_lv] = 1'b0;
                end else begin
                    o_lvl_req.wr_en        = 1'b1;
                    o_lvl_req.wr_addr      = r_lv;
                    o_lvl_req.wr_data.head = i_thr_rd.next;
                    o_lvl_req.wr_mask      = LVL_M_HEAD;
                end
                n_queued[r_t]    = 1'b0;
                n_run_level      = r_lv;
                n_run_valid      = 1'b1;
                o_res_load       = 1'b1;
                o_res.out_thread = 5'(r_t);
                o_res.out_level  = 5'(r_lv);
                o_res.quantum    = calc_quantum(5'(r_lv), i_cfg.quantum_max);
            end
            S_THR: begin
                if (w_cmd == CMD_REMOVE) begin
                    if (!w_queued) begin
                        o_res_load       = 1'b1;
                        o_res.out_thread = r_item.thread_id;
                        o_res.status     = ST_UNQUEUED;
                    end else begin
                        n_lv              = i_thr_rd.lvl;
                        n_t               = w_tid;
                        n_nx              = i_thr_rd.next;
                        n_pv              = i_thr_rd.prev;
                        o_lvl_req.rd_en   = 1'b1;
                        o_lvl_req.rd_addr = i_thr_rd.lvl;
                    end
                end else if (w_queued) begin
                    o_res_load       = 1'b1;
                    o_res.out_thread = r_item.thread_id;
                    o_res.out_level  = 5'(i_thr_rd.lvl);
                    o_res.quantum    = calc_quantum(5'(i_thr_rd.lvl), i_cfg.quantum_max);
                    o_res.status     = ST_QUEUED;
                end else if (!w_bit_set) begin
                    // First thread of an empty level: head and tail both point at it.
                    o_lvl_req.wr_en        = 1'b1;
                    o_lvl_req.wr_addr      = w_prio;
                    o_lvl_req.wr_data.head = w_tid;
                    o_lvl_req.wr_data.tail = w_tid;
                    o_lvl_req.wr_mask      = LVL_M_ALL;
                    o_thr_req.wr_en        = 1'b1;
                    o_thr_req.wr_addr      = w_tid;
                    o_thr_req.wr_data.lvl  = w_prio;
                    o_thr_req.wr_mask      = THR_M_LVL;
                    n_bitmap[w_prio]       = 1'b1;
                    n_queued[w_tid]        = 1'b1;
                    o_res_load             = 1'b1;
                    o_res.out_thread       = r_item.thread_id;
                    o_res.out_level        = 5'(w_prio);
                    o_res.quantum          = calc_quantum(5'(w_prio), i_cfg.quantum_max);
                    o_res.preempt          = w_preempt;
                end else begin
                    o_lvl_req.rd_en   = 1'b1;
                    o_lvl_req.rd_addr = w_prio;
                end
            end
            S_RM_LVL: begin
                n_queued[r_t]    = 1'b0;
                o_res_load       = 1'b1;
                o_res.out_thread = 5'(r_t);
                o_res.out_level  = 5'(r_lv);
                o_res.quantum    = calc_quantum(5'(r_lv), i_cfg.quantum_max);
                priority if (w_is_head && w_is_tail) begin
                    n_bitmap[r_lv] = 1'b0;
                end else if (w_is_head) begin
                    o_lvl_req.wr_en        = 1'b1;
                    o_lvl_req.wr_addr      = r_lv;
                    o_lvl_req.wr_data.head = r_nx;
                    o_lvl_req.wr_mask      = LVL_M_HEAD;
                end else if (w_is_tail) begin
                    o_lvl_req.wr_en        = 1'b1;
                    o_lvl_req.wr_addr      = r_lv;
                    o_lvl_req.wr_data.tail = r_pv;
                    o_lvl_req.wr_mask      = LVL_M_TAIL;
                end else begin
                    // Middle of the list: bridge the neighbors, next link here and prev link in S_RM_FIX.
                    o_thr_req.wr_en        = 1'b1;
                    o_thr_req.wr_addr      = r_pv;
                    o_thr_req.wr_data.next = r_nx;
                    o_thr_req.wr_mask      = THR_M_NEXT;
                end
            end
            S_RM_FIX: begin
                o_thr_req.wr_en        = 1'b1;
                o_thr_req.wr_addr      = r_nx;
                o_thr_req.wr_data.prev = r_pv;
                o_thr_req.wr_mask      = THR_M_PREV;
            end
            S_INS_LVL: begin
                o_thr_req.wr_en       = 1'b1;
                o_thr_req.wr_addr     = w_tid;
                o_thr_req.wr_data.lvl = w_prio;
                o_lvl_req.wr_en       = 1'b1;
                o_lvl_req.wr_addr     = w_prio;
                if (w_cmd == CMD_INS_HEAD) begin
                    o_thr_req.wr_data.next = i_lvl_rd.head;
                    o_thr_req.wr_mask      = THR_M_NEXT | THR_M_LVL;
                    o_lvl_req.wr_data.head = w_tid;
                    o_lvl_req.wr_mask      = LVL_M_HEAD;
                    n_other                = i_lvl_rd.head;
                end else begin
                    o_thr_req.wr_data.prev = i_lvl_rd.tail;
                    o_thr_req.wr_mask      = THR_M_PREV | THR_M_LVL;
                    o_lvl_req.wr_data.tail = w_tid;
                    o_lvl_req.wr_mask      = LVL_M_TAIL;
                    n_other                = i_lvl_rd.tail;
                end
                n_bitmap[w_prio] = 1'b1;
                n_queued[w_tid]  = 1'b1;
                o_res_load       = 1'b1;
                o_res.out_thread = r_item.thread_id;
                o_res.out_level  = 5'(w_prio);
                o_res.quantum    = calc_quantum(5'(w_prio), i_cfg.quantum_max);
                o_res.preempt    = w_preempt;
            end
            S_INS_FIX: begin
                o_thr_req.wr_en   = 1'b1;
                o_thr_req.wr_addr = r_other;
                if (w_cmd == CMD_INS_HEAD) begin
                    o_thr_req.wr_data.prev = w_tid;
                    o_thr_req.wr_mask      = THR_M_PREV;
                end else begin
                    o_thr_req.wr_data.next = w_tid;
                    o_thr_req.wr_mask      = THR_M_NEXT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bitmap    <= '0;
            r_queued    <= '0;
            r_run_level <= '0;
            r_run_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bitmap    <= n_bitmap;
            r_queued    <= n_queued;
            r_run_level <= n_run_level;
            r_run_valid <= n_run_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_in_data;
        end
        r_lv      <= n_lv;
        r_t       <= n_t;
        r_nx      <= n_nx;
        r_pv      <= n_pv;
        r_other   <= n_other;
        r_lvl_ent <= n_lvl_ent;
    end

endmodule

`default_nettype wire

/* verif/priority_ready_queue_scheduler_tb.sv */
// Self-checking testbench for the priority ready-queue scheduler.
`timescale 1ns / 100ps

module priority_ready_queue_scheduler_tb
    import prqs_pkg::*;
();

    localparam int CLK_HALF_NS     = 5;
    localparam int RUN_LIMIT_NS    = 5_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int BASE_QUANTUM    = 6;
    localparam int MIN_QUANTUM     = 2;
    localparam int REALTIME_LEVEL  = 16;
    localparam int THREAD_COUNT    = 32;
    localparam int LEVEL_COUNT     = 32;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = CFG_IDLE_THREAD;
    logic [4:0] i_cfg_data = '0;

    priority_ready_queue_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the ready queues, kept in step with accepted commands.
    logic [31:0] ready_map = '0;
    logic [4:0]  lvl_head [LEVEL_COUNT];
    logic [4:0]  lvl_tail [LEVEL_COUNT];
    logic [4:0]  link_next [THREAD_COUNT];
    logic [4:0]  link_prev [THREAD_COUNT];
    logic [4:0]  thr_level [THREAD_COUNT];
    logic        thr_queued [THREAD_COUNT];
    logic [4:0]  run_level = '0;
    logic        run_valid = 1'b0;
    logic [4:0]  cfg_idle = 5'd0;
    logic [3:0]  cfg_qmax = QMAX_RESET;

    t_out_item   pending_results [$];
    int          mismatch_count = 0;
    bit          idling_on = 1'b1;

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < THREAD_COUNT; i++) begin
            thr_queued[i] = 1'b0;
            link_next[i] = '0;
            link_prev[i] = '0;
            thr_level[i] = '0;
        end
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            lvl_head[i] = '0;
            lvl_tail[i] = '0;
        end
    end

    function automatic logic [3:0] quantum_for(input logic [4:0] lvl);
        int q;
        if (int'(lvl) >= REALTIME_LEVEL) begin
            q = BASE_QUANTUM + (int'(lvl) - REALTIME_LEVEL) / 2;
        end else begin
            q = BASE_QUANTUM - (REALTIME_LEVEL - int'(lvl)) / 4;
        end
        // The floor is applied before the ceiling, so a low ceiling only wins above it.
        if (q < MIN_QUANTUM) begin
            q = MIN_QUANTUM;
        end else if (q > int'(cfg_qmax)) begin
            q = int'(cfg_qmax);
        end
        return q[3:0];
    endfunction

    function automatic void detach_thread(input logic [4:0] t);
        logic [4:0] lv;
        logic [4:0] nx;
        logic [4:0] pv;
        lv = thr_level[t];
        nx = link_next[t];
        pv = link_prev[t];
        if (lvl_head[lv] == t && lvl_tail[lv] == t) begin
            ready_map[lv] = 1'b0;
        end else if (lvl_head[lv] == t) begin
            lvl_head[lv] = nx;
        end else if (lvl_tail[lv] == t) begin
            lvl_tail[lv] = pv;
        end else begin
            link_next[pv] = nx;
            link_prev[nx] = pv;
        end
        thr_queued[t] = 1'b0;
    endfunction

    function automatic t_out_item schedule_step(input t_in_item it);
        t_out_item  r;
        int         lv;
        logic [4:0] tid;
        logic [4:0] p;
        r = '0;
        r.status = ST_OK;
        tid = it.thread_id;
        p = it.priority_req;
        r.out_thread = tid;
        if (it.command == CMD_SELECT) begin
            if (ready_map != '0) begin
                lv = LEVEL_COUNT - 1;
                while (!ready_map[lv]) lv--;
                r.out_thread = lvl_head[lv];
                r.out_level = lv[4:0];
                detach_thread(lvl_head[lv]);
            end else begin
                r.out_thread = cfg_idle;
                r.went_idle = 1'b1;
            end
            r.quantum = quantum_for(r.out_level);
            run_level = r.out_level;
            run_valid = 1'b1;
        end else if (it.command == CMD_REMOVE) begin
            if (!thr_queued[tid]) begin
                r.status = ST_UNQUEUED;
            end else begin
                r.out_level = thr_level[tid];
                r.quantum = quantum_for(thr_level[tid]);
                detach_thread(tid);
            end
        end else if (thr_queued[tid]) begin
            r.status = ST_QUEUED;
            r.out_level = thr_level[tid];
            r.quantum = quantum_for(thr_level[tid]);
        end else begin
            if (!ready_map[p]) begin
                lvl_head[p] = tid;
                lvl_tail[p] = tid;
            end else if (it.command == CMD_INS_HEAD) begin
                link_next[tid] = lvl_head[p];
                link_prev[lvl_head[p]] = tid;
                lvl_head[p] = tid;
            end else begin
                link_prev[tid] = lvl_tail[p];
                link_next[lvl_tail[p]] = tid;
                lvl_tail[p] = tid;
            end
            ready_map[p] = 1'b1;
            thr_queued[tid] = 1'b1;
            thr_level[tid] = p;
            r.out_level = p;
            r.quantum = quantum_for(p);
            r.preempt = run_valid && (p > run_level);
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("mismatch in %s: expected %0d, got %0d", name, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("result beat with nothing expected: thread %0d level %0d",
                             o_out_data.out_thread, o_out_data.out_level);
                end
            end else begin
                want = pending_results.pop_front();
                check_field("out_thread", want.out_thread, o_out_data.out_thread);
                check_field("out_level", want.out_level, o_out_data.out_level);
                check_field("quantum", want.quantum, o_out_data.quantum);
                check_field("went_idle", want.went_idle, o_out_data.went_idle);
                check_field("preempt", want.preempt, o_out_data.preempt);
                check_field("status", want.status, o_out_data.status);
            end
        end
    end

    // Result-side backpressure comes in bursts; runs without stall are bursts too.
    int stall_run = 0;
    bit stall_now = 1'b0;
    always @(negedge i_clk) begin
        if (!idling_on) begin
            stall_now = 1'b0;
            stall_run = 0;
        end else if (stall_run == 0) begin
            stall_now = ($urandom_range(0, 2) == 0);
            stall_run = $urandom_range(1, 16);
        end else begin
            stall_run--;
        end
        i_out_stall <= stall_now;
    end

    task automatic send_command(input t_in_item it);
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pending_results.push_back(schedule_step(it));
    endtask

    task automatic issue(input t_cmd cmd, input logic [4:0] tid, input logic [4:0] prio);
        t_in_item it;
        it.command = cmd;
        it.thread_id = tid;
        it.priority_req = prio;
        send_command(it);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_register(input logic idx, input logic [4:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IDLE_THREAD) begin
            cfg_idle = value;
        end else begin
            cfg_qmax = value[3:0];
        end
    endtask

    function automatic t_in_item random_command(input int hot_level);
        t_in_item it;
        int       pool [THREAD_COUNT];
        int       n;
        int       roll;
        bit       want_queued;
        it.command = t_cmd'($urandom_range(0, 3));
        it.thread_id = 5'($urandom);
        it.priority_req = 5'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            // Inserts pick a free thread, removes a queued one.
            want_queued = (roll >= 38);
            n = 0;
            for (int i = 0; i < THREAD_COUNT; i++) begin
                if (thr_queued[i] == want_queued) begin
                    pool[n] = i;
                    n++;
                end
            end
            if (n > 0) begin
                it.thread_id = 5'(pool[$urandom_range(0, n - 1)]);
                if (want_queued) begin
                    it.command = CMD_REMOVE;
                end else begin
                    it.command = $urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL;
                    // Crowding a few levels builds long lists with middle entries.
                    if ($urandom_range(0, 2) != 0) begin
                        it.priority_req = 5'(hot_level + $urandom_range(0, 2));
                    end
                end
            end
        end else if (roll < 85) begin
            it.command = CMD_SELECT;
        end
        return it;
    endfunction

    task automatic run_random_batch(input int count);
        int sel;
        int hot_level;
        sel = $urandom_range(0, 2);
        program_register(CFG_IDLE_THREAD, (sel == 0) ? 5'd0 : (sel == 1) ? 5'd31 : 5'($urandom));
        sel = $urandom_range(0, 2);
        program_register(CFG_QUANTUM_MAX,
                         (sel == 0) ? 5'd2 : (sel == 1) ? 5'd15 : 5'($urandom_range(2, 15)));
        hot_level = $urandom_range(0, 29);
        for (int i = 0; i < count; i++) begin
            send_command(random_command(hot_level));
        end
        drain_results();
    endtask

    task automatic test_empty_and_single();
        issue(CMD_INS_TAIL, 5'd5, 5'd31);
        issue(CMD_SELECT, 5'd31, 5'd31);
        issue(CMD_SELECT, 5'd0, 5'd0);
    endtask

    task automatic test_list_surgery();
        issue(CMD_INS_TAIL, 5'd0, 5'd0);
        issue(CMD_INS_TAIL, 5'd31, 5'd7);
        issue(CMD_INS_TAIL, 5'd1, 5'd7);
        issue(CMD_INS_HEAD, 5'd2, 5'd7);
        issue(CMD_INS_TAIL, 5'd3, 5'd7);
        issue(CMD_INS_TAIL, 5'd31, 5'd20);
        issue(CMD_REMOVE, 5'd31, 5'd0);
        issue(CMD_REMOVE, 5'd3, 5'd0);
        issue(CMD_REMOVE, 5'd2, 5'd0);
        issue(CMD_REMOVE, 5'd1, 5'd0);
        issue(CMD_REMOVE, 5'd1, 5'd31);
    endtask

    task automatic test_preempt_and_order();
        issue(CMD_INS_HEAD, 5'd4, 5'd0);
        issue(CMD_INS_TAIL, 5'd30, 5'd16);
        issue(CMD_SELECT, 5'd0, 5'd0);
        issue(CMD_INS_TAIL, 5'd6, 5'd15);
        issue(CMD_INS_TAIL, 5'd7, 5'd17);
        issue(CMD_SELECT, 5'd0, 5'd0);
        issue(CMD_SELECT, 5'd0, 5'd0);
        drain_results();
    endtask

    task automatic test_config_extremes();
        program_register(CFG_IDLE_THREAD, 5'd31);
        program_register(CFG_QUANTUM_MAX, 5'd2);
        issue(CMD_SELECT, 5'd0, 5'd0);
        issue(CMD_SELECT, 5'd0, 5'd0);
        issue(CMD_SELECT, 5'd0, 5'd0);
        issue(CMD_INS_TAIL, 5'd9, 5'd31);
        issue(CMD_SELECT, 5'd0, 5'd0);
        drain_results();
        program_register(CFG_IDLE_THREAD, 5'd0);
        program_register(CFG_QUANTUM_MAX, 5'd15);
        issue(CMD_INS_HEAD, 5'd11, 5'd31);
        issue(CMD_SELECT, 5'd0, 5'd0);
        drain_results();
    endtask

    task automatic test_random_with_idling();
        idling_on = 1'b1;
        for (int b = 0; b < 4; b++) begin
            run_random_batch(220);
        end
    endtask

    task automatic test_random_back_to_back();
        idling_on = 1'b0;
        run_random_batch(120);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_single();
        test_list_surgery();
        test_preempt_and_order();
        test_config_extremes();
        test_random_with_idling();
        test_random_back_to_back();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/prqs_pkg.sv
rtl/core/prqs_ram.sv
rtl/core/prqs_ctrl.sv
rtl/core/priority_ready_queue_scheduler.sv
verif/priority_ready_queue_scheduler_tb.sv
